// ===== design/bdct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdct_pkg
// Shared types and constants of the BIOS disk call translator: function
// codes, configuration register indexes, pipeline stage records.
// ----------------------------------------------------------------------------
package bdct_pkg;

  // Function codes (AH)
  typedef enum logic [7:0] {
    OP_RESET      = 8'h00,
    OP_READ       = 8'h02,
    OP_WRITE      = 8'h03,
    OP_VERIFY     = 8'h04,
    OP_GET_PARAMS = 8'h08,
    OP_DISK_TYPE  = 8'h15,
    OP_SET_MEDIA  = 8'h18,
    OP_EXT_CHECK  = 8'h41,
    OP_EXT_READ   = 8'h42,
    OP_EXT_WRITE  = 8'h43,
    OP_EXT_PARAMS = 8'h48
  } op_e;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_DRIVE_NUMBER = 3'd0,
    CFG_HEADS        = 3'd1,
    CFG_SPT          = 3'd2,
    CFG_CYLINDERS    = 3'd3,
    CFG_DISK_SECTORS = 3'd4,
    CFG_DRIVE_COUNT  = 3'd5
  } cfg_idx_e;

  localparam logic [7:0]  DRIVE_NUMBER_RST = 8'h80;
  localparam logic [8:0]  HEADS_RST        = 9'd255;
  localparam logic [5:0]  SPT_RST          = 6'd63;
  localparam logic [31:0] CYLINDERS_RST    = 32'd1;
  localparam logic [31:0] DISK_SECTORS_RST = 32'd0;
  localparam logic [7:0]  DRIVE_COUNT_RST  = 8'd1;

  localparam logic [15:0] BOOT_SIG        = 16'haa55;
  localparam logic [31:0] CYL_CLAMP       = 32'd1024;
  localparam logic [15:0] CX_CYL_CLAMPED  = 16'hffc0;
  localparam logic [7:0]  AH_OK           = 8'h00;
  localparam logic [7:0]  AH_FAIL         = 8'h01;
  localparam logic [7:0]  AH_HARD_DISK    = 8'h03;
  localparam logic [15:0] EXT_SUPPORT_MAP = 16'h0001;

  localparam int unsigned IN_W      = 160;
  localparam int unsigned OUT_W     = 152;
  localparam int unsigned PROD1_W   = 19;  // 10-bit cylinder x 9-bit heads
  localparam int unsigned PROD2_W   = 26;  // (prod1 + head) x 6-bit spt

  // One call as it travels the pipeline
  typedef struct packed {
    logic [7:0]  op;
    logic        hit;   // known function for the served drive
    logic [7:0]  drive;
    logic [7:0]  al_count;
    logic [15:0] cx_word;
    logic [7:0]  head;
    logic [15:0] bx_word;
    logic [15:0] es_segment;
    logic [31:0] packet_lba;
    logic [15:0] packet_count;
    logic [15:0] packet_segment;
    logic [15:0] packet_offset;
  } call_t;

  // One result
  typedef struct packed {
    logic        unhandled;
    logic        carry;
    logic [7:0]  ah_out;
    logic [15:0] bx_out;
    logic [15:0] cx_out;
    logic [15:0] dx_out;
    logic        xfer_read;
    logic [31:0] xfer_lba;
    logic [15:0] xfer_count;
    logic [31:0] xfer_buffer;
    logic [10:0] param_cylinders;
  } result_t;

endpackage

// ===== design/bios_disk_call_translator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bios_disk_call_translator
// Translates BIOS disk service calls into status, register results and
// sector transfer requests for one served drive.
// ----------------------------------------------------------------------------
// Stages: a call is registered in stage 1, then stage 2, then the result register.
// Throughput: one call per cycle unless m_axis_tready stalls; the CHS-to-LBA
// multiply chain is split over the three stages (cylinder x heads, then x sectors per track).
// Reset: rst_ni clears all stage valid bits and loads the default geometry
// (drive 0x80, 255 heads, 63 sectors, 1 cylinder, 0 sectors, 1 drive).
// ----------------------------------------------------------------------------
module bios_disk_call_translator
  import bdct_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  // call input
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // op, drive, al_count, cx_word, head, bx_word, es_segment, packet_lba,
  // packet_count, packet_segment, packet_offset
  input  logic [IN_W-1:0]    s_axis_tdata,
  // result output
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // carry, ah_out, bx_out, cx_out, dx_out, xfer_read, xfer_lba, xfer_count,
  // xfer_buffer, param_cylinders, 3 zero bits
  output logic [OUT_W-1:0]   m_axis_tdata,
  // unhandled
  output logic               m_axis_tuser
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [7:0]  drive_number_q;
  logic [8:0]  heads_q;
  logic [5:0]  spt_q;
  logic [31:0] cylinders_q;
  logic [31:0] disk_sectors_q;
  logic [7:0]  drive_count_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_number_q <= DRIVE_NUMBER_RST;
      heads_q        <= HEADS_RST;
      spt_q          <= SPT_RST;
      cylinders_q    <= CYLINDERS_RST;
      disk_sectors_q <= DISK_SECTORS_RST;
      drive_count_q  <= DRIVE_COUNT_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_DRIVE_NUMBER: drive_number_q <= cfg_data_i[7:0];
        CFG_HEADS:        heads_q        <= cfg_data_i[8:0];
        CFG_SPT:          spt_q          <= cfg_data_i[5:0];
        CFG_CYLINDERS:    cylinders_q    <= cfg_data_i;
        CFG_DISK_SECTORS: disk_sectors_q <= cfg_data_i;
        CFG_DRIVE_COUNT:  drive_count_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline control: each stage advances when it is empty or drains
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q;
  logic rdy1, rdy2, rdy3;
  logic in_fire;

  assign rdy3          = !v3_q || m_axis_tready;
  assign rdy2          = !v2_q || rdy3;
  assign rdy1          = !v1_q || rdy2;
  assign s_axis_tready = rdy1;
  assign in_fire       = s_axis_tvalid && rdy1;
  assign m_axis_tvalid = v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: unpack, decode, cylinder x heads
  // --------------------------------------------------------------------------
  call_t               call_in;
  logic                known;
  logic [9:0]          cyl_in;
  call_t               s1_q;
  logic [PROD1_W-1:0]  prod1_d, prod1_q;

  always_comb begin
    call_in.op             = s_axis_tdata[7:0];
    call_in.drive          = s_axis_tdata[15:8];
    call_in.al_count       = s_axis_tdata[23:16];
    call_in.cx_word        = s_axis_tdata[39:24];
    call_in.head           = s_axis_tdata[47:40];
    call_in.bx_word        = s_axis_tdata[63:48];
    call_in.es_segment     = s_axis_tdata[79:64];
    call_in.packet_lba     = s_axis_tdata[111:80];
    call_in.packet_count   = s_axis_tdata[127:112];
    call_in.packet_segment = s_axis_tdata[143:128];
    call_in.packet_offset  = s_axis_tdata[159:144];

    unique case (call_in.op) inside
      OP_RESET, OP_READ, OP_WRITE, OP_VERIFY, OP_GET_PARAMS, OP_DISK_TYPE,
      OP_SET_MEDIA, OP_EXT_CHECK, OP_EXT_READ, OP_EXT_WRITE,
      OP_EXT_PARAMS: known = 1'b1;
      default:       known = 1'b0;
    endcase
    call_in.hit = known && (call_in.drive == drive_number_q);

    // cylinder: CL bits 7:6 above CH
    cyl_in  = {call_in.cx_word[7:6], call_in.cx_word[15:8]};
    prod1_d = PROD1_W'(cyl_in * heads_q);
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_q    <= call_in;
      prod1_q <= prod1_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: (cylinder x heads + head) x sectors per track
  // --------------------------------------------------------------------------
  call_t               s2_q;
  logic [PROD1_W:0]    track_idx;
  logic [PROD2_W-1:0]  prod2_d, prod2_q;

  assign track_idx = {1'b0, prod1_q} + (PROD1_W + 1)'(s1_q.head);
  assign prod2_d   = PROD2_W'(track_idx * spt_q);

  always_ff @(posedge clk_i) begin
    if (rdy2 && v1_q) begin
      s2_q    <= s1_q;
      prod2_q <= prod2_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: add sector, build the result
  // --------------------------------------------------------------------------
  result_t     res_d, res_q;
  logic [31:0] chs_lba;
  logic [31:0] max_cyl;

  assign chs_lba = 32'(prod2_q) + 32'(s2_q.cx_word[5:0]) - 32'd1;
  assign max_cyl = cylinders_q - 32'd1;

  always_comb begin
    res_d.unhandled       = 1'b0;
    res_d.carry           = 1'b0;
    res_d.ah_out          = AH_OK;
    res_d.bx_out          = s2_q.bx_word;
    res_d.cx_out          = s2_q.cx_word;
    res_d.dx_out          = {s2_q.head, s2_q.drive};
    res_d.xfer_read       = 1'b0;
    res_d.xfer_lba        = '0;
    res_d.xfer_count      = '0;
    res_d.xfer_buffer     = '0;
    res_d.param_cylinders = '0;

    if (!s2_q.hit) begin
      res_d.unhandled = 1'b1;
      res_d.carry     = 1'b1;
      res_d.ah_out    = AH_FAIL;
    end else begin
      unique case (s2_q.op) inside
        OP_READ, OP_WRITE: begin
          res_d.xfer_read   = (s2_q.op == OP_READ);
          res_d.xfer_lba    = chs_lba;
          res_d.xfer_count  = {8'h00, s2_q.al_count};
          res_d.xfer_buffer = {s2_q.es_segment, s2_q.bx_word};
        end
        OP_GET_PARAMS: begin
          // zero cylinders wraps to the clamped packing as well
          if (cylinders_q > CYL_CLAMP) begin
            res_d.cx_out = CX_CYL_CLAMPED | {10'd0, spt_q};
          end else begin
            res_d.cx_out = {max_cyl[7:0], 8'h00} | {max_cyl[17:8], 6'd0}
                         | {10'd0, spt_q};
          end
          res_d.dx_out = {heads_q[7:0] - 8'd1, drive_count_q};
        end
        OP_DISK_TYPE: begin
          res_d.ah_out = AH_HARD_DISK;
          res_d.cx_out = disk_sectors_q[31:16];
          res_d.dx_out = disk_sectors_q[15:0];
        end
        OP_SET_MEDIA: begin
          res_d.ah_out = AH_FAIL;
        end
        OP_EXT_CHECK: begin
          res_d.ah_out = AH_FAIL;
          res_d.bx_out = BOOT_SIG;
          res_d.cx_out = EXT_SUPPORT_MAP;
        end
        OP_EXT_READ, OP_EXT_WRITE: begin
          res_d.xfer_read   = (s2_q.op == OP_EXT_READ);
          res_d.xfer_lba    = s2_q.packet_lba;
          res_d.xfer_count  = s2_q.packet_count;
          res_d.xfer_buffer = {s2_q.packet_segment, s2_q.packet_offset};
        end
        OP_EXT_PARAMS: begin
          res_d.param_cylinders = (cylinders_q > CYL_CLAMP) ? CYL_CLAMP[10:0]
                                                           : cylinders_q[10:0];
        end
        default: ;  // reset and verify: status ok, registers echoed
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tuser = res_q.unhandled;
  assign m_axis_tdata = {3'b000,
                         res_q.param_cylinders,
                         res_q.xfer_buffer,
                         res_q.xfer_count,
                         res_q.xfer_lba,
                         res_q.xfer_read,
                         res_q.dx_out,
                         res_q.cx_out,
                         res_q.bx_out,
                         res_q.ah_out,
                         res_q.carry};

`ifndef NO_ASSERTIONS
  // input side stalls only when every stage holds a call
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q && v3_q))
    else $error("input stalled with an empty stage");

  // an accepted call reaches stage 1 on the next edge
  a_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> v1_q)
    else $error("accepted transaction lost at stage 1");

  // an unhandled call fails and requests no transfer
  a_unhandled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.unhandled) |->
      (res_q.carry && res_q.ah_out == AH_FAIL && res_q.xfer_count == '0))
    else $error("unhandled result carries a transfer or wrong status");

  // a transfer request is always a successful call
  a_xfer_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && res_q.xfer_count != '0) |-> !res_q.carry)
    else $error("transfer request with carry set");

  // parameter cylinders never exceed the clamp
  a_clamp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(res_q.param_cylinders) <= CYL_CLAMP))
    else $error("parameter cylinders above clamp");
`endif

endmodule

// ===== dv/bdct_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdct_scoreboard
// Watches the configuration, call and result channels of the disk call
// translator. Keeps its own copy of the geometry registers, computes the
// result of every accepted call and compares each result transaction, field
// by field, with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module bdct_scoreboard
  import bdct_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i,
  input  logic               call_valid_i,
  input  logic               call_ready_i,
  input  logic [IN_W-1:0]    call_data_i,
  input  logic               res_valid_i,
  input  logic               res_ready_i,
  input  logic [OUT_W-1:0]   res_data_i,
  input  logic               res_unhandled_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  // Call fields, last field in the top bits so the struct overlays tdata
  typedef struct packed {
    logic [15:0] packet_offset;
    logic [15:0] packet_segment;
    logic [15:0] packet_count;
    logic [31:0] packet_lba;
    logic [15:0] es_segment;
    logic [15:0] bx_word;
    logic [7:0]  head;
    logic [15:0] cx_word;
    logic [7:0]  al_count;
    logic [7:0]  drive;
    logic [7:0]  op;
  } disk_call_t;

  logic [7:0]  drive_number_q;
  logic [8:0]  heads_q;
  logic [5:0]  spt_q;
  logic [31:0] cylinders_q;
  logic [31:0] disk_sectors_q;
  logic [7:0]  drive_count_q;

  result_t expected_results_q[$];

  function automatic result_t translate_call(disk_call_t c);
    result_t     r;
    logic        known;
    logic [31:0] cyl;
    logic [31:0] max_cyl;
    logic [31:0] cx_pack;
    logic [8:0]  max_head;
    r           = '0;
    r.bx_out    = c.bx_word;
    r.cx_out    = c.cx_word;
    r.dx_out    = {c.head, c.drive};
    case (c.op) inside
      OP_RESET, OP_READ, OP_WRITE, OP_VERIFY, OP_GET_PARAMS, OP_DISK_TYPE,
      OP_SET_MEDIA, OP_EXT_CHECK, OP_EXT_READ, OP_EXT_WRITE, OP_EXT_PARAMS: known = 1'b1;
      default: known = 1'b0;
    endcase
    if (!known || c.drive != drive_number_q) begin
      r.unhandled = 1'b1;
      r.carry     = 1'b1;
      r.ah_out    = AH_FAIL;
    end else begin
      r.ah_out = AH_OK;
      case (c.op) inside
        OP_READ, OP_WRITE: begin
          // 10-bit cylinder: CH plus CL bits 7:6 on top; LBA wraps at 32 bits
          cyl = {24'b0, c.cx_word[15:8]} + {22'b0, c.cx_word[7:6], 8'b0};
          r.xfer_lba = (cyl * {23'b0, heads_q} + {24'b0, c.head}) * {26'b0, spt_q}
                       + {26'b0, c.cx_word[5:0]} - 32'd1;
          r.xfer_read   = (c.op == OP_READ);
          r.xfer_count  = {8'b0, c.al_count};
          r.xfer_buffer = {c.es_segment, c.bx_word};
        end
        OP_GET_PARAMS: begin
          max_cyl = cylinders_q - 32'd1;
          if (cylinders_q > CYL_CLAMP) begin
            cx_pack = {16'b0, CX_CYL_CLAMPED};
          end else begin
            cx_pack = {16'b0, max_cyl[7:0], 8'b0} | ((max_cyl >> 8) << 6);
          end
          r.cx_out = cx_pack[15:0] | {10'b0, spt_q};
          max_head = heads_q - 9'd1;
          r.dx_out = {max_head[7:0], drive_count_q};
        end
        OP_DISK_TYPE: begin
          r.ah_out = AH_HARD_DISK;
          r.cx_out = disk_sectors_q[31:16];
          r.dx_out = disk_sectors_q[15:0];
        end
        OP_SET_MEDIA: r.ah_out = AH_FAIL;
        OP_EXT_CHECK: begin
          r.ah_out = AH_FAIL;
          r.bx_out = BOOT_SIG;
          r.cx_out = EXT_SUPPORT_MAP;
        end
        OP_EXT_READ, OP_EXT_WRITE: begin
          r.xfer_read   = (c.op == OP_EXT_READ);
          r.xfer_lba    = c.packet_lba;
          r.xfer_count  = c.packet_count;
          r.xfer_buffer = {c.packet_segment, c.packet_offset};
        end
        OP_EXT_PARAMS: begin
          r.param_cylinders = (cylinders_q > CYL_CLAMP) ? CYL_CLAMP[10:0] : cylinders_q[10:0];
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    result_t             want;
    logic [OUT_W-1:0]    d;
    if (!rst_ni) begin
      drive_number_q = DRIVE_NUMBER_RST;
      heads_q        = HEADS_RST;
      spt_q          = SPT_RST;
      cylinders_q    = CYLINDERS_RST;
      disk_sectors_q = DISK_SECTORS_RST;
      drive_count_q  = DRIVE_COUNT_RST;
      expected_results_q.delete();
      fail_count_o   = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_DRIVE_NUMBER: drive_number_q = cfg_data_i[7:0];
          CFG_HEADS:        heads_q        = cfg_data_i[8:0];
          CFG_SPT:          spt_q          = cfg_data_i[5:0];
          CFG_CYLINDERS:    cylinders_q    = cfg_data_i;
          CFG_DISK_SECTORS: disk_sectors_q = cfg_data_i;
          CFG_DRIVE_COUNT:  drive_count_q  = cfg_data_i[7:0];
          default: ;
        endcase
      end
      // match the result against older calls before queuing this edge's call
      if (res_valid_i && res_ready_i) begin
        if (expected_results_q.size() == 0) begin
          $error("result transaction with no call outstanding");
          fail_count_o++;
        end else begin
          want = expected_results_q.pop_front();
          d    = res_data_i;
          check_field("unhandled",       32'(want.unhandled),       32'(res_unhandled_i));
          check_field("carry",           32'(want.carry),           32'(d[0]));
          check_field("ah_out",          32'(want.ah_out),          32'(d[8:1]));
          check_field("bx_out",          32'(want.bx_out),          32'(d[24:9]));
          check_field("cx_out",          32'(want.cx_out),          32'(d[40:25]));
          check_field("dx_out",          32'(want.dx_out),          32'(d[56:41]));
          check_field("xfer_read",       32'(want.xfer_read),       32'(d[57]));
          check_field("xfer_lba",        want.xfer_lba,             d[89:58]);
          check_field("xfer_count",      32'(want.xfer_count),      32'(d[105:90]));
          check_field("xfer_buffer",     want.xfer_buffer,          d[137:106]);
          check_field("param_cylinders", 32'(want.param_cylinders), 32'(d[148:138]));
        end
      end
      if (call_valid_i && call_ready_i) begin
        expected_results_q.push_back(translate_call(disk_call_t'(call_data_i)));
      end
    end
    pending_o = expected_results_q.size();
  end

endmodule

// ===== dv/tb_bios_disk_call_translator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bios_disk_call_translator
// Drives BIOS disk service calls into the translator across a series of
// drive geometries, from directed corner calls to random traffic with
// random idling on both streams, a long result back-pressure and a drain
// pause. The scoreboard does all checking; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_bios_disk_call_translator;
  import bdct_pkg::*;

  localparam int unsigned LIMIT_CYCLES    = 200000;
  localparam int unsigned CALLS_PER_PHASE = 95;
  localparam int unsigned NUM_PHASES      = 9;
  localparam int unsigned HOLD_CYCLES     = 60;
  localparam int unsigned DRAIN_CYCLES    = 10;

  localparam op_e KNOWN_OPS [11] = '{OP_RESET, OP_READ, OP_WRITE, OP_VERIFY,
                                     OP_GET_PARAMS, OP_DISK_TYPE, OP_SET_MEDIA,
                                     OP_EXT_CHECK, OP_EXT_READ, OP_EXT_WRITE,
                                     OP_EXT_PARAMS};

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [2:0]        cfg_index;
  logic [31:0]       cfg_data;
  logic              s_tvalid;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata;
  logic              m_tvalid;
  logic              m_tready;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tuser;

  int                fail_count;
  int                pending;
  int unsigned       cycles = 0;
  logic [7:0]        served_drive = DRIVE_NUMBER_RST;
  bit                burst = 1'b0;
  bit                hold_req = 1'b0;
  bit                offering = 1'b0;

  always #2 clk_i = ~clk_i;

  bios_disk_call_translator DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  bdct_scoreboard u_scoreboard (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_i     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .call_valid_i    (s_tvalid),
    .call_ready_i    (s_tready),
    .call_data_i     (s_tdata),
    .res_valid_i     (m_tvalid),
    .res_ready_i     (m_tready),
    .res_data_i      (m_tdata),
    .res_unhandled_i (m_tuser),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result side: random stalls, none in burst mode, one long hold on request
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        m_tready <= burst || ($urandom_range(99) >= 19);
      end
    end
  end

  function automatic logic [IN_W-1:0] pack_call(
    logic [7:0] op, logic [7:0] drive, logic [7:0] al, logic [15:0] cx,
    logic [7:0] head, logic [15:0] bx, logic [15:0] es, logic [31:0] plba,
    logic [15:0] pcnt, logic [15:0] pseg, logic [15:0] poff);
    return {poff, pseg, pcnt, plba, es, bx, head, cx, al, drive, op};
  endfunction

  // Mostly known functions aimed at the served drive, the rest noise
  function automatic logic [IN_W-1:0] random_call();
    logic [7:0] op;
    logic [7:0] drive;
    op    = ($urandom_range(99) < 85) ? KNOWN_OPS[$urandom_range(10)] : 8'($urandom);
    drive = ($urandom_range(99) < 90) ? served_drive : 8'($urandom);
    return pack_call(op, drive, 8'($urandom), 16'($urandom), 8'($urandom),
                     16'($urandom), 16'($urandom), $urandom, 16'($urandom),
                     16'($urandom), 16'($urandom));
  endfunction

  task automatic send_call(logic [IN_W-1:0] d);
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    offering = 1'b1;
    do @(posedge clk_i); while (!s_tready);
    // drop valid, then keep idling with the same odds
    if (!burst && $urandom_range(99) < 19) begin
      s_tvalid <= 1'b0;
      offering = 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < 19) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait until every outstanding call has its result
  task automatic drain_calls();
    if (offering) begin
      s_tvalid <= 1'b0;
      offering = 1'b0;
    end
    @(posedge clk_i);
    wait (pending == 0);
    @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  task automatic set_geometry(logic [31:0] drive_number, logic [31:0] heads,
                              logic [31:0] spt, logic [31:0] cylinders,
                              logic [31:0] disk_sectors, logic [31:0] drive_count);
    write_reg(CFG_DRIVE_NUMBER, drive_number);
    write_reg(CFG_HEADS, heads);
    write_reg(CFG_SPT, spt);
    write_reg(CFG_CYLINDERS, cylinders);
    write_reg(CFG_DISK_SECTORS, disk_sectors);
    write_reg(CFG_DRIVE_COUNT, drive_count);
    cfg_valid <= 1'b0;
    served_drive = drive_number[7:0];
    @(posedge clk_i);
  endtask

  initial begin
    rst_ni    <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_DRIVE_NUMBER;
    cfg_data  <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed calls against the reset geometry
    send_call(pack_call(OP_RESET, 8'h80, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                        32'h0, 16'h0, 16'h0, 16'h0));
    send_call(pack_call(OP_VERIFY, 8'h80, 8'hff, 16'hffff, 8'hff, 16'hffff, 16'hffff,
                        32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff));
    // oversize CHS: every cylinder, head and sector bit set
    send_call(pack_call(OP_READ, 8'h80, 8'hff, 16'hffff, 8'hff, 16'hffff, 16'hffff,
                        32'h0, 16'h0, 16'h0, 16'h0));
    // sector zero wraps the LBA below zero
    send_call(pack_call(OP_WRITE, 8'h80, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                        32'h0, 16'h0, 16'h0, 16'h0));
    send_call(pack_call(OP_READ, 8'h80, 8'h01, 16'h0001, 8'h00, 16'h7c00, 16'h0000,
                        32'h0, 16'h0, 16'h0, 16'h0));
    send_call(pack_call(OP_WRITE, 8'h80, 8'h80, 16'h03c1, 8'h7f, 16'h1234, 16'h8000,
                        32'h0, 16'h0, 16'h0, 16'h0));
    send_call(pack_call(OP_GET_PARAMS, 8'h80, 8'h00, 16'h5a5a, 8'h12, 16'h0000, 16'h0000,
                        32'h0, 16'h0, 16'h0, 16'h0));
    send_call(pack_call(OP_DISK_TYPE, 8'h80, 8'h00, 16'h1111, 8'h22, 16'h3333, 16'h0000,
                        32'h0, 16'h0, 16'h0, 16'h0));
    send_call(pack_call(OP_SET_MEDIA, 8'h80, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                        32'h0, 16'h0, 16'h0, 16'h0));
    send_call(pack_call(OP_EXT_CHECK, 8'h80, 8'h00, 16'h0000, 8'h00, 16'h55aa, 16'h0000,
                        32'h0, 16'h0, 16'h0, 16'h0));
    send_call(pack_call(OP_EXT_READ, 8'h80, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                        32'hffff_ffff, 16'hffff, 16'hffff, 16'hffff));
    send_call(pack_call(OP_EXT_WRITE, 8'h80, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                        32'h0, 16'h0, 16'h0, 16'h0));
    send_call(pack_call(OP_EXT_PARAMS, 8'h80, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                        32'h0, 16'h0, 16'h0, 16'h0));
    // unknown functions and foreign drives
    send_call(pack_call(8'hff, 8'h80, 8'h01, 16'h0101, 8'h01, 16'h0101, 16'h0101,
                        32'h1, 16'h1, 16'h1, 16'h1));
    send_call(pack_call(8'h01, 8'h80, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                        32'h0, 16'h0, 16'h0, 16'h0));
    send_call(pack_call(OP_READ, 8'h00, 8'h01, 16'h0001, 8'h00, 16'h0000, 16'h0000,
                        32'h0, 16'h0, 16'h0, 16'h0));
    send_call(pack_call(OP_EXT_READ, 8'hff, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                        32'h1000, 16'h8, 16'h0, 16'h0));
    send_call(pack_call(OP_GET_PARAMS, 8'h81, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0000,
                        32'h0, 16'h0, 16'h0, 16'h0));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph > 0) begin
        drain_calls();
        case (ph)
          // exactly at the cylinder clamp
          1: set_geometry(32'h80, 32'd16, 32'd63, 32'd1024, 32'h00fb_0400, 32'd1);
          // low extremes, zero cylinders
          2: set_geometry(32'h00, 32'd1, 32'd1, 32'd0, 32'h0, 32'd0);
          3: set_geometry(32'hff, 32'd256, 32'd63, 32'hffff_ffff, 32'hffff_ffff, 32'hff);
          // heads and sectors out of range, one past the clamp
          4: set_geometry(32'h81, 32'd0, 32'd0, 32'd1025, 32'h1234_5678, 32'd2);
          5: set_geometry(32'h80, 32'd511, 32'd17, 32'd1023, 32'h000f_ffff, 32'd1);
          default: set_geometry($urandom, $urandom, $urandom, $urandom_range(0, 2047),
                                $urandom, $urandom);
        endcase
      end
      burst = (ph == 2);
      for (int n = 0; n < CALLS_PER_PHASE; n++) begin
        if (ph == 1 && n == 30) begin
          // stall the result side while calls keep coming
          burst    = 1'b1;
          hold_req = 1'b1;
        end
        if (ph == 1 && n == 70) burst = 1'b0;
        if (ph == 4 && n == 50) drain_calls();
        send_call(random_call());
      end
    end

    drain_calls();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
